### rtl/fit_allocator_with_coalescing_top_assert.svh
// Assertion macros for the fit allocator top level.
// Depends on signals named clk and rst in the scope where they are used.
`ifndef FIT_ALLOCATOR_WITH_COALESCING_TOP_ASSERT_SVH
`define FIT_ALLOCATOR_WITH_COALESCING_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fit allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define FAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fit allocator assertion failed");

`endif

### rtl/fac_pkg.sv
// Package for the fit allocator: codes, table entry types and sequencer states.
// Used by fac_cfg and fit_allocator_with_coalescing_top; depends on nothing.
`timescale 1ns / 1ps

package fac_pkg;

  localparam int ADDR_W       = 3;
  localparam int INIT_ENTRIES = 5;

  typedef enum logic [0:0] {
    REG_FIT_MODE    = 1'b0,
    REG_MERGE_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_LOAD    = 2'd0,
    K_ALLOC   = 2'd1,
    K_TERM    = 2'd2,
    K_DEALLOC = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic        fit_mode;
    logic [24:0] merge_limit;
  } cfg_t;

  typedef struct packed {
    logic [23:0] start;
    logic [24:0] size;
  } free_ent_t;

  typedef struct packed {
    logic [23:0] start;
    logic [24:0] size;
    logic [7:0]  pid;
    logic [7:0]  bid;
  } used_ent_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_A_RD, S_A_CHK, S_A_END,
    S_D_RD, S_D_WR,
    S_R_RD, S_R_CHK, S_U_RD, S_U_WR,
    S_G_START, S_G_RD, S_G_CHK,
    S_I_RD, S_I_WR, S_I_PUT,
    S_M_RD0, S_M_LD, S_M_RD1, S_M_CHK
  } state_t;

endpackage

### rtl/fac_cfg.sv
// Configuration registers of the fit allocator behind an APB-style port.
// Depends on fac_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module fac_cfg #(
  parameter int MEGABYTE = 1048576
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fac_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output fac_pkg::cfg_t              cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fit_mode    <= 1'b0;
      cfg.merge_limit <= 25'(4 * MEGABYTE);
    end else if (wr) begin
      if (paddr[2] == fac_pkg::REG_FIT_MODE) begin
        cfg.fit_mode <= pwdata[0];
      end else begin
        cfg.merge_limit <= pwdata[24:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == fac_pkg::REG_MERGE_LIMIT) begin
      prdata = {7'd0, cfg.merge_limit};
    end else begin
      prdata = {31'd0, cfg.fit_mode};
    end
  end

endmodule

### rtl/fit_allocator_with_coalescing_top.sv
// The cost of a request grows with the free or in-use entries visited and the entries moved; a request
// to a full in-use table is answered from idle, and a terminate that frees many blocks costs most.
// Throughput: one request at a time, busy is high while a request is in progress; the cost is
// set by the single read port of each table. No receiver stall.
// Reset loads the free table with its initial entries while busy is high.
// Depends on fac_pkg, fac_cfg and fit_allocator_with_coalescing_top_assert.svh.
`timescale 1ns / 1ps
`include "fit_allocator_with_coalescing_top_assert.svh"

module fit_allocator_with_coalescing_top #(
  parameter int USED_SLOTS = 32,
  parameter int FREE_SLOTS = 64,
  parameter int MEGABYTE   = 1048576
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind,
  input  logic [7:0]                 process_id,
  input  logic [7:0]                 block_id,
  input  logic [23:0]                request_size,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [23:0]                start_address,
  output logic [5:0]                 freed_blocks,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fac_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int FIW = $clog2(FREE_SLOTS);
  localparam int UCW = $clog2(USED_SLOTS + 1);
  localparam int UIW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;

  fac_pkg::cfg_t cfg;

  fac_cfg #(.MEGABYTE(MEGABYTE)) u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  fac_pkg::state_t state, state_next;

  fac_pkg::free_ent_t fmem [FREE_SLOTS];
  fac_pkg::used_ent_t umem [USED_SLOTS];
  fac_pkg::free_ent_t f_rdata, f_wdata;
  fac_pkg::used_ent_t u_rdata, u_wdata;
  logic [FIW-1:0] f_raddr, f_waddr;
  logic [UIW-1:0] u_raddr, u_waddr;
  logic           f_we, u_we;

  logic [FCW-1:0] fcount, fi, k, pos, mi, pick;
  logic [UCW-1:0] ucount, ui, ku;
  logic [2:0]     ic;
  logic [1:0]     r_kind;
  logic [7:0]     r_pid, r_bid;
  logic [23:0]    r_req;
  logic           found, drop_merge;
  logic [24:0]    best;
  logic [23:0]    pick_start, rel_start, cur_start;
  logic [24:0]    pick_size, rel_size, cur_size;
  logic [5:0]     freed;

  logic [FCW-1:0] kp1, km1, mip1;
  logic [UCW-1:0] kup1, uim1;
  logic           fit_ok, better, match, merge_ok, full;
  logic [24:0]    left, pick_left;
  logic [25:0]    msum;
  fac_pkg::free_ent_t init_ent;

  assign kp1       = k + 1'b1;
  assign km1       = k - 1'b1;
  assign mip1      = mi + 1'b1;
  assign kup1      = ku + 1'b1;
  assign uim1      = ui - 1'b1;
  assign fit_ok    = f_rdata.size >= 25'(r_req);
  assign left      = f_rdata.size - 25'(r_req);
  assign better    = !found || (cfg.fit_mode && (left < best));
  assign pick_left = pick_size - 25'(r_req);
  assign match     = (u_rdata.pid == r_pid) &&
                     ((r_kind == fac_pkg::K_TERM) || (u_rdata.bid == r_bid));
  assign msum      = 26'(cur_size) + 26'(f_rdata.size);
  assign merge_ok  = ((26'(cur_start) + 26'(cur_size)) == 26'(f_rdata.start)) &&
                     (msum <= 26'(cfg.merge_limit));
  assign full      = ucount >= UCW'(USED_SLOTS);
  assign busy      = (state != fac_pkg::S_IDLE);

  always_comb begin
    case (ic)
      3'd0:    init_ent = '{start: 24'(3 * MEGABYTE),  size: 25'(1 * MEGABYTE)};
      3'd1:    init_ent = '{start: 24'(4 * MEGABYTE),  size: 25'(2 * MEGABYTE)};
      3'd2:    init_ent = '{start: 24'(6 * MEGABYTE),  size: 25'(2 * MEGABYTE)};
      3'd3:    init_ent = '{start: 24'(8 * MEGABYTE),  size: 25'(4 * MEGABYTE)};
      default: init_ent = '{start: 24'(12 * MEGABYTE), size: 25'(4 * MEGABYTE)};
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    f_rdata <= fmem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      umem[u_waddr] <= u_wdata;
    end
    u_rdata <= umem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fac_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    f_raddr    = '0;
    f_we       = 1'b0;
    f_waddr    = '0;
    f_wdata    = '0;
    u_raddr    = '0;
    u_we       = 1'b0;
    u_waddr    = '0;
    u_wdata    = '0;
    case (state)
      fac_pkg::S_INIT: begin
        f_we    = 1'b1;
        f_waddr = FIW'(ic);
        f_wdata = init_ent;
        if (ic == 3'(fac_pkg::INIT_ENTRIES - 1)) begin
          state_next = fac_pkg::S_IDLE;
        end
      end
      fac_pkg::S_IDLE: begin
        if (start) begin
          if (kind == fac_pkg::K_LOAD || kind == fac_pkg::K_ALLOC) begin
            state_next = full ? fac_pkg::S_IDLE : fac_pkg::S_A_RD;
          end else begin
            state_next = fac_pkg::S_R_RD;
          end
        end
      end
      fac_pkg::S_A_RD: begin
        f_raddr = fi[FIW-1:0];
        state_next = (fi == fcount) ? fac_pkg::S_A_END : fac_pkg::S_A_CHK;
      end
      fac_pkg::S_A_CHK: begin
        if (fit_ok && !cfg.fit_mode) begin
          state_next = fac_pkg::S_A_END;
        end else begin
          state_next = fac_pkg::S_A_RD;
        end
      end
      fac_pkg::S_A_END: begin
        if (!found) begin
          state_next = fac_pkg::S_IDLE;
        end else begin
          u_we    = 1'b1;
          u_waddr = ucount[UIW-1:0];
          u_wdata = '{start: pick_start, size: 25'(r_req), pid: r_pid, bid: r_bid};
          if (pick_left == '0) begin
            state_next = fac_pkg::S_D_RD;
          end else begin
            f_we       = 1'b1;
            f_waddr    = pick[FIW-1:0];
            f_wdata    = '{start: pick_start + r_req, size: pick_left};
            state_next = fac_pkg::S_IDLE;
          end
        end
      end
      fac_pkg::S_D_RD: begin
        f_raddr = kp1[FIW-1:0];
        if (kp1 >= fcount) begin
          state_next = drop_merge ? fac_pkg::S_M_RD1 : fac_pkg::S_IDLE;
        end else begin
          state_next = fac_pkg::S_D_WR;
        end
      end
      fac_pkg::S_D_WR: begin
        f_we       = 1'b1;
        f_waddr    = k[FIW-1:0];
        f_wdata    = f_rdata;
        state_next = fac_pkg::S_D_RD;
      end
      fac_pkg::S_R_RD: begin
        u_raddr = uim1[UIW-1:0];
        state_next = (ui == '0) ? fac_pkg::S_IDLE : fac_pkg::S_R_CHK;
      end
      fac_pkg::S_R_CHK: begin
        state_next = match ? fac_pkg::S_U_RD : fac_pkg::S_R_RD;
      end
      fac_pkg::S_U_RD: begin
        u_raddr = kup1[UIW-1:0];
        state_next = (kup1 >= ucount) ? fac_pkg::S_G_START : fac_pkg::S_U_WR;
      end
      fac_pkg::S_U_WR: begin
        u_we       = 1'b1;
        u_waddr    = ku[UIW-1:0];
        u_wdata    = u_rdata;
        state_next = fac_pkg::S_U_RD;
      end
      fac_pkg::S_G_START: begin
        state_next = (fcount >= FCW'(FREE_SLOTS)) ? fac_pkg::S_R_RD : fac_pkg::S_G_RD;
      end
      fac_pkg::S_G_RD: begin
        f_raddr = fi[FIW-1:0];
        state_next = (fi == fcount) ? fac_pkg::S_I_RD : fac_pkg::S_G_CHK;
      end
      fac_pkg::S_G_CHK: begin
        state_next = (f_rdata.start > rel_start) ? fac_pkg::S_I_RD : fac_pkg::S_G_RD;
      end
      fac_pkg::S_I_RD: begin
        f_raddr = km1[FIW-1:0];
        state_next = (k == pos) ? fac_pkg::S_I_PUT : fac_pkg::S_I_WR;
      end
      fac_pkg::S_I_WR: begin
        f_we       = 1'b1;
        f_waddr    = k[FIW-1:0];
        f_wdata    = f_rdata;
        state_next = fac_pkg::S_I_RD;
      end
      fac_pkg::S_I_PUT: begin
        f_we       = 1'b1;
        f_waddr    = pos[FIW-1:0];
        f_wdata    = '{start: rel_start, size: rel_size};
        state_next = fac_pkg::S_M_RD0;
      end
      fac_pkg::S_M_RD0: begin
        f_raddr = mi[FIW-1:0];
        state_next = (mi >= fcount) ? fac_pkg::S_R_RD : fac_pkg::S_M_LD;
      end
      fac_pkg::S_M_LD: begin
        state_next = fac_pkg::S_M_RD1;
      end
      fac_pkg::S_M_RD1: begin
        f_raddr = mip1[FIW-1:0];
        state_next = (mip1 >= fcount) ? fac_pkg::S_R_RD : fac_pkg::S_M_CHK;
      end
      fac_pkg::S_M_CHK: begin
        if (merge_ok) begin
          f_we       = 1'b1;
          f_waddr    = mi[FIW-1:0];
          f_wdata    = '{start: cur_start, size: msum[24:0]};
          state_next = fac_pkg::S_D_RD;
        end else begin
          state_next = fac_pkg::S_M_RD1;
        end
      end
      default: begin
        state_next = fac_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= FCW'(fac_pkg::INIT_ENTRIES);
      ucount <= '0;
      ic     <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        fac_pkg::S_INIT: begin
          ic <= ic + 1'b1;
        end
        fac_pkg::S_IDLE: begin
          r_kind <= kind;
          r_pid  <= process_id;
          r_bid  <= block_id;
          r_req  <= request_size;
          fi     <= '0;
          found  <= 1'b0;
          ui     <= ucount;
          freed  <= '0;
          start_address <= '0;
          freed_blocks  <= '0;
          status        <= fac_pkg::ST_OK;
          if (start && (kind == fac_pkg::K_LOAD || kind == fac_pkg::K_ALLOC) && full) begin
            status <= fac_pkg::ST_FULL;
            done   <= 1'b1;
          end
        end
        fac_pkg::S_A_CHK: begin
          if (fit_ok && better) begin
            found      <= 1'b1;
            pick       <= fi;
            best       <= left;
            pick_start <= f_rdata.start;
            pick_size  <= f_rdata.size;
          end
          fi <= fi + 1'b1;
        end
        fac_pkg::S_A_END: begin
          if (!found) begin
            status <= fac_pkg::ST_NO_FIT;
            done   <= 1'b1;
          end else begin
            start_address <= pick_start;
            ucount        <= ucount + 1'b1;
            k             <= pick;
            drop_merge    <= 1'b0;
            if (pick_left != '0) begin
              done <= 1'b1;
            end
          end
        end
        fac_pkg::S_D_RD: begin
          if (kp1 >= fcount) begin
            fcount <= fcount - 1'b1;
            if (!drop_merge) begin
              done <= 1'b1;
            end
          end
        end
        fac_pkg::S_D_WR: begin
          k <= kp1;
        end
        fac_pkg::S_R_RD: begin
          if (ui == '0) begin
            status       <= (freed == '0) ? fac_pkg::ST_NOT_FOUND : fac_pkg::ST_OK;
            freed_blocks <= freed;
            done         <= 1'b1;
          end
        end
        fac_pkg::S_R_CHK: begin
          if (match) begin
            rel_start <= u_rdata.start;
            rel_size  <= u_rdata.size;
            freed     <= freed + 1'b1;
            ku        <= uim1;
          end else begin
            ui <= uim1;
          end
        end
        fac_pkg::S_U_RD: begin
          if (kup1 >= ucount) begin
            ucount <= ucount - 1'b1;
            ui     <= uim1;
            fi     <= '0;
          end
        end
        fac_pkg::S_U_WR: begin
          ku <= kup1;
        end
        fac_pkg::S_G_RD: begin
          if (fi == fcount) begin
            pos <= fcount;
            k   <= fcount;
          end
        end
        fac_pkg::S_G_CHK: begin
          if (f_rdata.start > rel_start) begin
            pos <= fi;
            k   <= fcount;
          end else begin
            fi <= fi + 1'b1;
          end
        end
        fac_pkg::S_I_WR: begin
          k <= km1;
        end
        fac_pkg::S_I_PUT: begin
          fcount     <= fcount + 1'b1;
          mi         <= '0;
          drop_merge <= 1'b1;
        end
        fac_pkg::S_M_LD: begin
          cur_start <= f_rdata.start;
          cur_size  <= f_rdata.size;
        end
        fac_pkg::S_M_CHK: begin
          if (merge_ok) begin
            cur_size <= msum[24:0];
            k        <= mip1;
          end else begin
            cur_start <= f_rdata.start;
            cur_size  <= f_rdata.size;
            mi        <= mip1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `FAC_ASSERT_IMP(a_done_after_req, done, $past(busy) || $past(start))
  `FAC_ASSERT_IMP(a_used_bound, 1'b1, ucount <= UCW'(USED_SLOTS))
  `FAC_ASSERT_NXT(a_start_takes, start && !busy, busy || done)
  `FAC_ASSERT_IMP(a_fail_addr_zero, done && status != fac_pkg::ST_OK, start_address == '0)

endmodule
